// File: design/quaternion_to_axis_angle_macros.svh
// assertion macros shared by the quaternion to axis-angle converter
`ifndef QUATERNION_TO_AXIS_ANGLE_MACROS_SVH
`define QUATERNION_TO_AXIS_ANGLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define QAA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define QAA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/qaa_pkg.sv
// types, constants and elaboration-time angle tables for the converter
`timescale 1ns / 1ps
package qaa_pkg;

  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
  localparam logic [31:0] ONE_Q30    = 32'd1073741824;

  // data handed along the sqrt and cordic cells
  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic [30:0]        s;
  } side_t;

  // sqrt cell data: remainder plus partial root in side.s
  typedef struct packed {
    logic [61:0] rem;
    side_t       side;
  } sqrt_t;

  // divider cell data, three lanes
  typedef struct packed {
    logic [30:0]       s;
    logic [30:0]       theta;
    logic              force_zero;
    logic              s_zero;
    logic [2:0]        neg;
    logic [2:0]        nz;
    logic [2:0]        over;
    logic [2:0][61:0]  rem;
    logic [2:0][30:0]  quo;
  } div_t;

  // one finished result
  typedef struct packed {
    logic [30:0]        angle;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic               sat;
  } res_t;

  // atan(2^-a) in Q62 from its power series, Machin's formula for a = 0
  function automatic logic [63:0] atan_q62(input int a);
    logic [63:0] sum;
    logic [63:0] s5;
    logic [63:0] s239;
    logic [63:0] p;
    logic [63:0] t;
    int          e;
    sum  = '0;
    s5   = '0;
    s239 = '0;
    if (a == 0) begin
      p = 64'h4000_0000_0000_0000 / 5;
      for (int k = 0; k < 40; k++) begin
        t = p / 64'(2 * k + 1);
        if (k % 2 == 1) s5 = s5 - t;
        else s5 = s5 + t;
        p = p / 25;
      end
      p = 64'h4000_0000_0000_0000 / 239;
      for (int k = 0; k < 40; k++) begin
        t = p / 64'(2 * k + 1);
        if (k % 2 == 1) s239 = s239 - t;
        else s239 = s239 + t;
        p = p / 57121;
      end
      sum = 64'd4 * s5 - s239;
    end else begin
      for (int k = 0; k < 63; k++) begin
        e = a * (2 * k + 1);
        if (e <= 62) begin
          t = (64'd1 << (62 - e)) / 64'(2 * k + 1);
          if (k % 2 == 1) sum = sum - t;
          else sum = sum + t;
        end
      end
    end
    return sum;
  endfunction

  // round a Q62 value to frac fraction bits, half up
  function automatic logic [63:0] to_frac(input logic [63:0] q62, input int frac);
    int sh;
    sh = 62 - frac;
    return (q62 >> sh) + ((q62 >> (sh - 1)) & 64'd1);
  endfunction

endpackage

// File: design/qaa_sqrt_cell.sv
// one bit of the restoring square root chain
`timescale 1ns / 1ps
module qaa_sqrt_cell import qaa_pkg::*; #(
  parameter int BIT = 30
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  v_in,
  input  sqrt_t d_in,
  output logic  v_out,
  output sqrt_t d_out
);

  logic [61:0] trial;
  sqrt_t       d_next;

  // trial = root * 2^(BIT+1) + 2^(2*BIT)
  always_comb begin
    trial  = (62'(d_in.side.s) << (BIT + 1)) | (62'd1 << (2 * BIT));
    d_next = d_in;
    if (d_in.rem >= trial) begin
      d_next.rem         = d_in.rem - trial;
      d_next.side.s[BIT] = 1'b1;
    end
  end

  // valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

// File: design/qaa_cordic_cell.sv
// one vectoring micro-rotation of the arctangent chain
`timescale 1ns / 1ps
module qaa_cordic_cell import qaa_pkg::*; #(
  parameter int STEP      = 0,
  parameter int FRAC_BITS = 30
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       v_in,
  input  side_t                      side_in,
  input  logic signed [63:0]         x_in,
  input  logic signed [63:0]         y_in,
  input  logic signed [FRAC_BITS+3:0] z_in,
  output logic                       v_out,
  output side_t                      side_out,
  output logic signed [63:0]         x_out,
  output logic signed [63:0]         y_out,
  output logic signed [FRAC_BITS+3:0] z_out
);

  localparam int ZW = FRAC_BITS + 4;
  localparam logic signed [ZW-1:0] ANGLE = ZW'(to_frac(atan_q62(STEP), FRAC_BITS));

  logic signed [63:0]   dx;
  logic signed [63:0]   dy;
  logic signed [63:0]   x_next;
  logic signed [63:0]   y_next;
  logic signed [ZW-1:0] z_next;

  // rotate toward the x axis
  always_comb begin
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
    if (y_in > 0) begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + ANGLE;
    end else begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - ANGLE;
    end
  end

  // valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
    end
  end

endmodule

// File: design/qaa_div_cell.sv
// one quotient bit of the three-lane restoring divider
`timescale 1ns / 1ps
module qaa_div_cell import qaa_pkg::*; #(
  parameter int BIT = 30
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic v_in,
  input  div_t d_in,
  output logic v_out,
  output div_t d_out
);

  logic [61:0] trial;
  div_t        d_next;

  // subtract the shifted divisor where it fits
  always_comb begin
    trial  = 62'(d_in.s) << BIT;
    d_next = d_in;
    for (int j = 0; j < 3; j++) begin
      if (d_in.rem[j] >= trial) begin
        d_next.rem[j]      = d_in.rem[j] - trial;
        d_next.quo[j][BIT] = 1'b1;
      end
    end
  end

  // valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

// File: design/quaternion_to_axis_angle.sv
// quaternion to axis-angle converter: sqrt, cordic and divider cell chains
// stages: 1 square, 31 sqrt cells, 1 cordic setup, CORDIC_STEPS cordic cells,
// 1 angle/numerator stage, 31 divider cells, 1 output register
// throughput: one beat per cycle; a two-entry output skid stalls the chain when full
// reset: rst synchronous active high clears all valids and angle_zero_limit to 0
`timescale 1ns / 1ps
`include "quaternion_to_axis_angle_macros.svh"
module quaternion_to_axis_angle import qaa_pkg::*; #(
  parameter int FRAC_BITS    = 30,
  parameter int CORDIC_STEPS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] q_w,
  input  logic signed [31:0] q_x,
  input  logic signed [31:0] q_y,
  input  logic signed [31:0] q_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        angle,
  output logic signed [31:0] axis_x,
  output logic signed [31:0] axis_y,
  output logic signed [31:0] axis_z,
  output logic               axis_saturated
);

  localparam int ZW = FRAC_BITS + 4;
  localparam logic signed [ZW-1:0] PI_F =
    ZW'(to_frac(64'd4 * atan_q62(0), FRAC_BITS));
  localparam logic signed [ZW-1:0] HALF_PI_F =
    ZW'(to_frac(64'd2 * atan_q62(0), FRAC_BITS));

  logic        en;
  logic [30:0] angle_zero_limit;

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_zero_limit <= '0;
    end else if (cfg_valid) begin
      angle_zero_limit <= cfg_data;
    end
  end

  // input stage: clamp w and form 2^60 - w^2
  logic signed [31:0] wc;
  logic signed [63:0] wsq;
  sqrt_t              sq   [0:31];
  logic [31:0]        sq_v;

  always_comb begin
    if (q_w > $signed(ONE_Q30)) wc = $signed(ONE_Q30);
    else if (q_w < -$signed(ONE_Q30)) wc = -$signed(ONE_Q30);
    else wc = q_w;
    wsq = 64'(wc) * 64'(wc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].rem     <= 62'((64'd1 << 60) - 64'(wsq));
      sq[0].side.w  <= wc;
      sq[0].side.qx <= q_x;
      sq[0].side.qy <= q_y;
      sq[0].side.qz <= q_z;
      sq[0].side.s  <= '0;
    end
  end

  // square root chain, one root bit per cell
  for (genvar i = 0; i < 31; i++) begin : g_sqrt
    qaa_sqrt_cell #(.BIT(30 - i)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .v_in  (sq_v[i]),
      .d_in  (sq[i]),
      .v_out (sq_v[i+1]),
      .d_out (sq[i+1])
    );
  end

  // cordic setup: fold the vector into the right half plane
  side_t                cd_side [0:CORDIC_STEPS];
  logic signed [63:0]   cd_x    [0:CORDIC_STEPS];
  logic signed [63:0]   cd_y    [0:CORDIC_STEPS];
  logic signed [ZW-1:0] cd_z    [0:CORDIC_STEPS];
  logic [CORDIC_STEPS:0] cd_v;
  logic signed [63:0]   s_q60;
  logic signed [63:0]   w_q60;

  assign s_q60 = $signed(64'(sq[31].side.s) << 30);
  assign w_q60 = 64'(sq[31].side.w) <<< 30;

  always_ff @(posedge clk) begin
    if (rst) begin
      cd_v[0] <= 1'b0;
    end else if (en) begin
      cd_v[0] <= sq_v[31];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd_side[0] <= sq[31].side;
      if (sq[31].side.w < 0) begin
        cd_x[0] <= s_q60;
        cd_y[0] <= -w_q60;
        cd_z[0] <= HALF_PI_F;
      end else begin
        cd_x[0] <= w_q60;
        cd_y[0] <= s_q60;
        cd_z[0] <= '0;
      end
    end
  end

  // cordic chain
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    qaa_cordic_cell #(.STEP(i), .FRAC_BITS(FRAC_BITS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (cd_v[i]),
      .side_in  (cd_side[i]),
      .x_in     (cd_x[i]),
      .y_in     (cd_y[i]),
      .z_in     (cd_z[i]),
      .v_out    (cd_v[i+1]),
      .side_out (cd_side[i+1]),
      .x_out    (cd_x[i+1]),
      .y_out    (cd_y[i+1]),
      .z_out    (cd_z[i+1])
    );
  end

  // angle finish and divider numerators
  side_t                ps;
  logic                 p_szero;
  logic signed [ZW-1:0] half;
  logic [63:0]          half64;
  logic [63:0]          th64;
  logic [30:0]          theta;
  logic [2:0][31:0]     qv;
  logic [2:0][31:0]     mag;
  logic [2:0][61:0]     num;
  logic [61:0]          lim;
  div_t                 dv   [0:31];
  logic [31:0]          dv_v;
  div_t                 prep;

  assign ps      = cd_side[CORDIC_STEPS];
  assign p_szero = (ps.s == '0);
  assign half64  = 64'(half);

  always_comb begin
    if (p_szero) half = (ps.w > 0) ? '0 : PI_F;
    else if (cd_z[CORDIC_STEPS] < 0) half = '0;
    else if (cd_z[CORDIC_STEPS] > PI_F) half = PI_F;
    else half = cd_z[CORDIC_STEPS];
  end

  if (FRAC_BITS <= 29) begin : g_th_up
    assign th64 = half64 << (29 - FRAC_BITS);
  end else begin : g_th_dn
    assign th64 = (half64 + (64'd1 << (FRAC_BITS - 30))) >> (FRAC_BITS - 29);
  end

  assign theta = (th64 > 64'(TWO_PI_Q28)) ? TWO_PI_Q28 : th64[30:0];
  assign qv    = {ps.qz, ps.qy, ps.qx};
  assign lim   = (62'(ps.s) << 30) + 62'(ps.s);

  always_comb begin
    prep            = '0;
    prep.s          = ps.s;
    prep.theta      = theta;
    prep.force_zero = (theta <= angle_zero_limit);
    prep.s_zero     = p_szero;
    for (int j = 0; j < 3; j++) begin
      prep.neg[j]  = qv[j][31];
      prep.nz[j]   = (qv[j] != '0);
      mag[j]       = qv[j][31] ? (~qv[j] + 32'd1) : qv[j];
      num[j]       = {mag[j], 30'b0} + 62'(ps.s >> 1);
      prep.over[j] = (num[j] >= lim);
      prep.rem[j]  = num[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= cd_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= prep;
    end
  end

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < 31; i++) begin : g_div
    qaa_div_cell #(.BIT(30 - i)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .v_in  (dv_v[i]),
      .d_in  (dv[i]),
      .v_out (dv_v[i+1]),
      .d_out (dv[i+1])
    );
  end

  // result assembly with saturation
  div_t             df;
  res_t             res;
  logic [2:0][31:0] lane;
  logic [31:0]      m;

  assign df = dv[31];

  always_comb begin
    m = '0;
    for (int j = 0; j < 3; j++) begin
      if (df.force_zero) begin
        lane[j] = '0;
      end else if (df.s_zero) begin
        lane[j] = df.neg[j] ? -ONE_Q30 : (df.nz[j] ? ONE_Q30 : '0);
      end else begin
        m       = df.over[j] ? ONE_Q30 : {1'b0, df.quo[j]};
        lane[j] = df.neg[j] ? -m : m;
      end
    end
    res.angle = df.theta;
    res.ax    = lane[0];
    res.ay    = lane[1];
    res.az    = lane[2];
    res.sat   = !df.force_zero && (df.s_zero || (df.over != '0));
  end

  // output register plus skid entry
  res_t out_r;
  res_t skid_r;
  logic skid_valid;
  logic push;

  assign en       = !skid_valid;
  assign in_ready = en;
  assign push     = en && dv_v[31];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_r      <= skid_r;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_r     <= res;
        skid_valid <= 1'b1;
      end else begin
        out_r     <= res;
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign angle          = out_r.angle;
  assign axis_x         = out_r.ax;
  assign axis_y         = out_r.ay;
  assign axis_z         = out_r.az;
  assign axis_saturated = out_r.sat;

  // checks
  `QAA_ASSERT_NOW(a_skid_implies_out, skid_valid, out_valid, "skid full with output empty")
  `QAA_ASSERT_NOW(a_angle_range, out_valid, angle <= TWO_PI_Q28, "angle above two pi")
  `QAA_ASSERT_NOW(a_sat_above_limit, out_valid && axis_saturated,
                  angle > angle_zero_limit, "saturation flagged on a forced-zero axis")
  `QAA_ASSERT_NEXT(a_skid_drains, skid_valid && out_ready, !skid_valid,
                   "skid entry not moved to output")

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the quaternion to axis-angle converter
`timescale 1ns / 1ps
module tb_top;
  import qaa_pkg::*;

  localparam longint ONE = 64'sd1073741824;
  localparam logic signed [31:0] Q_ONE = 32'sd1073741824;
  localparam int FRAC = 30;
  localparam int STEPS = 32;
  localparam int IDLE_WAIT = STEPS + 90;
  localparam int STALL_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [30:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] q_w = '0;
  logic signed [31:0] q_x = '0;
  logic signed [31:0] q_y = '0;
  logic signed [31:0] q_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [30:0]        angle;
  logic signed [31:0] axis_x;
  logic signed [31:0] axis_y;
  logic signed [31:0] axis_z;
  logic               axis_saturated;

  quaternion_to_axis_angle i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .q_w(q_w), .q_x(q_x), .q_y(q_y), .q_z(q_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
    .axis_saturated(axis_saturated)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  res_t        pending_rot[$];
  logic [30:0] zero_limit = '0;
  longint      atan_tab[STEPS];
  longint      pi_half_max;
  longint      neg_start;
  int          errors = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          cfg_writes = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          cyc = 0;
  int          rx_mode = 0;

  // atan(1/n) in Q62 by series
  function automatic longint unsigned atan_inv_q62(input longint unsigned n);
    longint unsigned p, sum, k, t;
    p = (64'd1 << 62) / n;
    sum = 0;
    k = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      if (k[0]) sum = sum - t;
      else sum = sum + t;
      p = p / (n * n);
      k++;
    end
    return sum;
  endfunction

  // atan(2^-a) in Q62
  function automatic longint unsigned atan_pow2_q62(input int a);
    longint unsigned sum, t;
    int e;
    sum = 0;
    if (a == 0) return 4 * atan_inv_q62(5) - atan_inv_q62(239);
    for (int k = 0; k < 63; k++) begin
      e = a * (2 * k + 1);
      if (e <= 62) begin
        t = (64'd1 << (62 - e)) / (2 * k + 1);
        if (k % 2 == 1) sum = sum - t;
        else sum = sum + t;
      end
    end
    return sum;
  endfunction

  function automatic longint round_q62(input longint unsigned v);
    return longint'((v >> (62 - FRAC)) + ((v >> (61 - FRAC)) & 64'd1));
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint axis_quot(input longint q, input longint unsigned s,
                                       inout logic sat);
    longint unsigned mag, r;
    mag = (q < 0) ? longint'(-q) : q;
    if (s == 0) begin
      sat = 1'b1;
      return (q > 0) ? ONE : ((q < 0) ? -ONE : 0);
    end
    r = ((mag << 30) + s / 2) / s;
    if (r > ONE) begin
      sat = 1'b1;
      r = ONE;
    end
    return (q < 0) ? -longint'(r) : longint'(r);
  endfunction

  // expected angle and axis for one quaternion
  function automatic res_t rotation_of(input logic signed [31:0] wi, xi, yi, zi,
                                       input logic [30:0] lim);
    res_t r;
    longint w, x, y, z, dx, dy, half;
    longint unsigned s, theta;
    logic sat;
    w = longint'(wi);
    if (w > ONE) w = ONE;
    if (w < -ONE) w = -ONE;
    s = int_sqrt(longint'(ONE * ONE - w * w));
    sat = 1'b0;
    if (s == 0) begin
      half = (w > 0) ? 0 : pi_half_max;
    end else begin
      if (w < 0) begin
        x = longint'(s) * ONE;
        y = -w * ONE;
        z = neg_start;
      end else begin
        x = w * ONE;
        y = longint'(s) * ONE;
        z = 0;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx; y = y - dy; z = z + atan_tab[i];
        end else begin
          x = x - dx; y = y + dy; z = z - atan_tab[i];
        end
      end
      half = z;
      if (half < 0) half = 0;
      if (half > pi_half_max) half = pi_half_max;
    end
    theta = (longint'(half) + 1) >> 1;
    if (theta > TWO_PI_Q28) theta = TWO_PI_Q28;
    r.angle = theta[30:0];
    r.ax = '0;
    r.ay = '0;
    r.az = '0;
    if (theta > lim) begin
      r.ax = 32'(axis_quot(xi, s, sat));
      r.ay = 32'(axis_quot(yi, s, sat));
      r.az = 32'(axis_quot(zi, s, sat));
    end
    r.sat = sat;
    return r;
  endfunction

  // input and config monitor: predict on each accepted beat
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      pending_rot.push_back(rotation_of(q_w, q_x, q_y, q_z, zero_limit));
      beats_in++;
    end
    if (!rst && cfg_valid && cfg_ready) begin
      zero_limit <= cfg_data;
      cfg_writes++;
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (pending_rot.size() == 0) begin
        $display("%0t: unexpected result beat, angle %0d", $time, angle);
        errors++;
      end else begin
        e = pending_rot.pop_front();
        if (angle !== e.angle) begin
          $display("%0t: angle expected %0d actual %0d", $time, e.angle, angle);
          errors++;
        end
        if (axis_x !== e.ax) begin
          $display("%0t: axis_x expected %0d actual %0d", $time, e.ax, axis_x);
          errors++;
        end
        if (axis_y !== e.ay) begin
          $display("%0t: axis_y expected %0d actual %0d", $time, e.ay, axis_y);
          errors++;
        end
        if (axis_z !== e.az) begin
          $display("%0t: axis_z expected %0d actual %0d", $time, e.az, axis_z);
          errors++;
        end
        if (axis_saturated !== e.sat) begin
          $display("%0t: axis_saturated expected %0b actual %0b", $time, e.sat,
                   axis_saturated);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, mode picked at random from four
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 256 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= (cyc % 7) < 4;
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one quaternion beat, sender in bursts with gaps
  task automatic send_quat(input logic signed [31:0] w, x, y, z);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    q_w <= w;
    q_x <= x;
    q_y <= y;
    q_z <= z;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_rot.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  // limit register write, only with the pipe empty
  task automatic write_limit(input logic [30:0] v);
    drain_results();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_q30();
    return 32'($signed(longint'($urandom_range(0, 32'h8000_0000)) - ONE));
  endfunction

  function automatic logic signed [31:0] to_q30(input real v);
    longint r;
    r = longint'($rtoi(v * 1073741824.0));
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return 32'(r);
  endfunction

  task automatic send_unit_random;
    real a, b, c, d, n;
    a = real'($urandom_range(0, 2000000)) - 1000000.0;
    b = real'($urandom_range(0, 2000000)) - 1000000.0;
    c = real'($urandom_range(0, 2000000)) - 1000000.0;
    d = real'($urandom_range(0, 2000000)) - 1000000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) begin
      a = 1.0;
      n = 1.0;
    end
    send_quat(to_q30(a / n), to_q30(b / n), to_q30(c / n), to_q30(d / n));
  endtask

  task automatic test_directed;
    send_quat(Q_ONE, 0, 0, 0);
    send_quat(-Q_ONE, 0, 0, 0);
    send_quat(Q_ONE, Q_ONE, -Q_ONE, 0);
    send_quat(-Q_ONE, -Q_ONE, Q_ONE, 5);
    send_quat(0, Q_ONE, 0, 0);
    send_quat(0, 0, -Q_ONE, 0);
    send_quat(0, 0, 0, Q_ONE);
    send_quat(0, -Q_ONE, -Q_ONE, -Q_ONE);
    send_quat(Q_ONE - 1, 46341, 0, 0);
    send_quat(Q_ONE - 1, -46341, 1, -1);
    send_quat(-Q_ONE + 1, 0, 46341, 0);
    send_quat(Q_ONE - 1, Q_ONE, -Q_ONE, 1000);
    send_quat(759250125, 759250125, 0, 0);
    send_quat(-759250125, 0, 0, -759250125);
    send_quat(536870912, 536870912, 536870912, 536870912);
    send_quat(-536870912, -536870912, 536870912, -536870912);
    send_quat(1, Q_ONE, 0, 0);
    send_quat(-1, 0, Q_ONE, 0);
    send_quat(32'h7fff_0000 >>> 1, 32'h8000 >>> 1, -3, 7);
  endtask

  task automatic test_limit_extremes;
    write_limit(TWO_PI_Q28);
    send_quat(0, Q_ONE, 0, 0);
    send_quat(-Q_ONE, 0, 0, 0);
    send_quat(-Q_ONE + 1, 0, 46341, 0);
    send_quat(Q_ONE - 1, 46341, 0, 0);
    write_limit(31'd843314857);
    send_quat(0, Q_ONE, 0, 0);
    send_quat(1, 0, Q_ONE, 0);
    send_quat(-1, 0, 0, Q_ONE);
    write_limit(31'd1);
    send_quat(Q_ONE - 1, 46341, 0, 0);
    send_quat(Q_ONE, 0, 0, 0);
  endtask

  // mostly unit quaternions, some near identity or a full turn, some raw values
  task automatic test_random_mix(input int count);
    logic signed [31:0] w;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1: send_quat(rand_q30(), rand_q30(), rand_q30(), rand_q30());
        2: begin
          w = Q_ONE - 32'($urandom_range(0, 4000));
          if ($urandom_range(0, 1)) w = -w;
          send_quat(w, $urandom_range(0, 200000) - 100000, $urandom_range(0, 2000) - 1000,
                    $urandom_range(0, 200000) - 100000);
        end
        default: send_unit_random();
      endcase
    end
  endtask

  task automatic test_random_limits;
    for (int p = 0; p < 4; p++) begin
      write_limit(31'($urandom_range(0, TWO_PI_Q28)));
      test_random_mix(150);
    end
  endtask

  initial begin
    for (int i = 0; i < STEPS; i++) atan_tab[i] = round_q62(atan_pow2_q62(i));
    pi_half_max = round_q62(4 * atan_pow2_q62(0));
    neg_start = round_q62(2 * atan_pow2_q62(0));
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix(200);
    test_limit_extremes();
    test_random_limits();
    write_limit(31'd0);
    test_random_mix(50);
    drain_results();
    $display("covered %0d quaternions, %0d results, %0d limit writes", beats_in, beats_out,
             cfg_writes);
    $display("angle limit swept from zero to two pi with random receiver stalls");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: quaternion_to_axis_angle.f
+incdir+design
design/qaa_pkg.sv
design/qaa_sqrt_cell.sv
design/qaa_cordic_cell.sv
design/qaa_div_cell.sv
design/quaternion_to_axis_angle.sv
tb/tb_top.sv
